/* sv/mit_pkg.sv */
// Shared types and constants for the interval timer.
`timescale 1ns / 1ps
`default_nettype none

package mit_pkg;

   // Item operation codes
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // Register word offsets within the window
   localparam logic [4:0] OFS_LENGTH   = 5'd31;
   localparam logic [4:0] OFS_MODE     = 5'd30;
   localparam logic [4:0] OFS_STAGE_HI = 5'd27;
   localparam logic [4:0] OFS_STAGE_LO = 5'd26;
   localparam logic [4:0] OFS_LIMIT_HI = 5'd25;
   localparam logic [4:0] OFS_LIMIT_LO = 5'd24;

   localparam logic [15:0] WINDOW_LEN = 16'h0040;

   // Mode/control register bit positions
   localparam int CTRL_RUN_BIT  = 0;
   localparam int CTRL_NMI_BIT  = 1;
   localparam int CTRL_IRQ_BIT  = 2;
   localparam int CTRL_LOAD_BIT = 8;
   localparam int CTRL_COPY_BIT = 9;
   localparam int CTRL_ACK_BIT  = 10;

   typedef struct packed {
      logic [1:0]  op;
      logic [4:0]  register_offset;
      logic [15:0] write_data;
      logic [31:0] tick_cycles;
   } mit_item_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic        pending;
      logic        irq_request;
      logic        nmi_request;
   } mit_result_type;

endpackage

`default_nettype wire

/* sv/mit_if.sv */
// Valid/ready channel interfaces for timer items and results.
`timescale 1ns / 1ps
`default_nettype none

interface mit_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [4:0]  register_offset;
   logic [15:0] write_data;
   logic [31:0] tick_cycles;

   modport source (output valid, op, register_offset, write_data, tick_cycles, input ready);
   modport sink   (input valid, op, register_offset, write_data, tick_cycles, output ready);
endinterface

interface mit_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] read_data;
   logic        pending;
   logic        irq_request;
   logic        nmi_request;

   modport source (output valid, read_data, pending, irq_request, nmi_request, input ready);
   modport sink   (input valid, read_data, pending, irq_request, nmi_request, output ready);
endinterface

`default_nettype wire

/* sv/mit_core.sv */
// Timer state and single-pass item logic.
`timescale 1ns / 1ps
`default_nettype none

module mit_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  mit_pkg::mit_item_type   item,
   output mit_pkg::mit_result_type result
);
   import mit_pkg::*;

   logic [31:0] count_ff, count_in;
   logic [31:0] stage_ff, stage_in;
   logic [31:0] limit_ff, limit_in;
   logic        run_ff, run_in;
   logic        nmi_ff, nmi_in;
   logic        irq_ff, irq_in;
   logic        pend_ff, pend_in;

   logic [32:0] sum;
   logic [31:0] after;
   logic        wrap;
   logic        hit;
   logic [15:0] rd;

   // tick window: old count .. new count, inclusive, across the wrap
   assign sum   = {1'b0, count_ff} + {1'b0, item.tick_cycles};
   assign after = sum[31:0];
   assign wrap  = sum[32];
   assign hit   = wrap ? ((limit_ff <= after) || (limit_ff >= count_ff))
                       : ((limit_ff >= count_ff) && (limit_ff <= after));

   always_comb begin
      count_in = count_ff;
      stage_in = stage_ff;
      limit_in = limit_ff;
      run_in   = run_ff;
      nmi_in   = nmi_ff;
      irq_in   = irq_ff;
      pend_in  = pend_ff;
      rd       = '0;
      case (item.op)
         OP_READ: begin
            unique case (item.register_offset)
               OFS_LENGTH:   rd = WINDOW_LEN;
               OFS_MODE:     rd = {13'd0, irq_ff, nmi_ff, run_ff};
               OFS_STAGE_HI: rd = stage_ff[31:16];
               OFS_STAGE_LO: rd = stage_ff[15:0];
               OFS_LIMIT_HI: rd = limit_ff[31:16];
               OFS_LIMIT_LO: rd = limit_ff[15:0];
               default:      rd = '0;
            endcase
         end
         OP_WRITE: begin
            unique case (item.register_offset)
               OFS_MODE: begin
                  run_in = item.write_data[CTRL_RUN_BIT];
                  nmi_in = item.write_data[CTRL_NMI_BIT];
                  irq_in = item.write_data[CTRL_IRQ_BIT];
                  // both copies see the pre-write values
                  if (item.write_data[CTRL_LOAD_BIT]) count_in = stage_ff;
                  if (item.write_data[CTRL_COPY_BIT]) stage_in = count_ff;
                  if (item.write_data[CTRL_ACK_BIT])  pend_in  = 1'b0;
               end
               OFS_STAGE_HI: stage_in = {item.write_data, stage_ff[15:0]};
               OFS_STAGE_LO: stage_in = {stage_ff[31:16], item.write_data};
               OFS_LIMIT_HI: limit_in = {item.write_data, limit_ff[15:0]};
               OFS_LIMIT_LO: limit_in = {limit_ff[31:16], item.write_data};
               default: ;
            endcase
         end
         OP_TICK: begin
            if (run_ff) begin
               count_in = after;
               if (hit) pend_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         stage_ff <= '0;
         limit_ff <= '0;
         run_ff   <= 1'b0;
         nmi_ff   <= 1'b0;
         irq_ff   <= 1'b0;
         pend_ff  <= 1'b0;
      end else if (step) begin
         count_ff <= count_in;
         stage_ff <= stage_in;
         limit_ff <= limit_in;
         run_ff   <= run_in;
         nmi_ff   <= nmi_in;
         irq_ff   <= irq_in;
         pend_ff  <= pend_in;
      end
   end

   assign result.read_data   = rd;
   assign result.pending     = pend_in;
   assign result.irq_request = pend_in & irq_in;
   assign result.nmi_request = pend_in & nmi_in;

endmodule

`default_nettype wire

/* sv/mmio_interval_timer_top.sv */
// Top level of the MMIO interval timer: channel registers around the timer core.
//
// Usage notes:
//  - req_chan carries one item per transfer: a register read, a register
//    write or a tick of tick_cycles clock cycles. rsp_chan returns exactly
//    one result per item, in order: read_data (zero except for reads),
//    pending, and the irq/nmi requests gated by their mode bits.
//  - Order: an item transferred on req_chan sits in the input register, is
//    evaluated against the timer state by the core, and its result is loaded
//    into the output register, which offers it on rsp_chan, once that register can take it.
//  - Throughput: one item per cycle while rsp_chan accepts results, set by the
//    single 32-bit add and window compare between the input and output registers.
//  - Stall: if rsp_chan is not ready, the output register holds its result
//    and the input register holds one more item; req_chan.ready drops only
//    once both are full.
//  - Reset (synchronous, active high) clears counter, staging, limit, mode
//    bits and pending, and empties both registers.
`timescale 1ns / 1ps
`default_nettype none

module mmio_interval_timer_top (
   input  logic      clock,
   input  logic      reset,
   mit_req_if.sink   req_chan,
   mit_rsp_if.source rsp_chan
);
   import mit_pkg::*;

   // input stage
   logic           in_valid_ff, in_valid_in;
   mit_item_type   in_item_ff;
   // output stage
   logic           out_valid_ff, out_valid_in;
   mit_result_type out_result_ff;
   mit_result_type core_result;

   logic req_xfer;   // item transfer on req_chan
   logic out_load;   // output register can take a new result
   logic advance;    // input item evaluated and retired this cycle

   assign out_load       = !out_valid_ff || rsp_chan.ready;
   assign advance        = in_valid_ff && out_load;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer)     in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
      out_valid_in = out_load ? in_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_item_ff.op              <= req_chan.op;
         in_item_ff.register_offset <= req_chan.register_offset;
         in_item_ff.write_data      <= req_chan.write_data;
         in_item_ff.tick_cycles     <= req_chan.tick_cycles;
      end
      if (advance) out_result_ff <= core_result;
   end

   // state commits only when the item's result is captured
   mit_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .result (core_result)
   );

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.read_data   = out_result_ff.read_data;
   assign rsp_chan.pending     = out_result_ff.pending;
   assign rsp_chan.irq_request = out_result_ff.irq_request;
   assign rsp_chan.nmi_request = out_result_ff.nmi_request;

`ifndef SYNTHESIS
   a_reset_empties: assert property (@(posedge clock)
      reset |=> (!in_valid_ff && !out_valid_ff))
      else $error("pipeline not empty after reset");

   a_full_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("req accepted while both stages are full");

   a_request_needs_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> ((!rsp_chan.irq_request && !rsp_chan.nmi_request)
                          || rsp_chan.pending))
      else $error("interrupt request without pending flag");

   a_stall_holds_result: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_chan.ready) |=> $stable(out_result_ff))
      else $error("stalled result overwritten");
`endif

endmodule

`default_nettype wire

/* sim/mmio_interval_timer_top_tb.sv */
// Self-checking testbench for the MMIO interval timer: directed and random items, scoreboard.
`timescale 1ns / 1ps

module mmio_interval_timer_top_tb;
   import mit_pkg::*;

   // op value outside the defined set; the block must treat it as a no-op
   localparam logic [1:0] OP_UNDEFINED = 2'd3;

   localparam int RANDOM_ITEMS = 750;
   localparam int IDLE_PCT     = 17;
   localparam int CYCLE_LIMIT  = 100000;
   localparam int HOLD_CYCLES  = 80;   // long receiver hold-off
   localparam int HOLD_AT      = 300;  // transfers accepted before the hold-off starts
   localparam int DRAIN_CYCLES = 20;

   logic clock;
   logic reset;

   mit_req_if req_bus ();
   mit_rsp_if rsp_bus ();

   mmio_interval_timer_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // Timer shadow state, advanced once per accepted request transfer
   // ---------------------------------------------------------------------
   logic [31:0] tmr_count;
   logic [31:0] tmr_stage;
   logic [31:0] tmr_limit;
   logic        tmr_run;
   logic        tmr_nmi_en;
   logic        tmr_irq_en;
   logic        tmr_pending;

   mit_item_type   queued_items[$];   // stimulus not yet offered
   mit_result_type awaited_rsp[$];    // predicted responses, oldest first

   int  accepted_count;
   int  total_items;
   int  mismatch_count;
   int  cycle_count;
   logic req_took;   // request transfer seen at the last rising edge
   logic calm;       // stretch with no idling on either side

   assign calm = (accepted_count >= 120) && (accepted_count < 260);

   // Apply one item to the shadow state and return the response it yields.
   function automatic mit_result_type advance_timer(input mit_item_type it);
      mit_result_type r;
      logic [31:0] prior;
      logic [31:0] later;
      logic [31:0] old_count;
      logic [31:0] old_stage;
      logic [15:0] wd;
      logic hit;
      r  = '0;
      wd = it.write_data;
      case (it.op)
         OP_READ: begin
            case (it.register_offset)
               OFS_LENGTH:   r.read_data = WINDOW_LEN;
               OFS_MODE: begin
                  r.read_data[CTRL_RUN_BIT] = tmr_run;
                  r.read_data[CTRL_NMI_BIT] = tmr_nmi_en;
                  r.read_data[CTRL_IRQ_BIT] = tmr_irq_en;
               end
               OFS_STAGE_HI: r.read_data = tmr_stage[31:16];
               OFS_STAGE_LO: r.read_data = tmr_stage[15:0];
               OFS_LIMIT_HI: r.read_data = tmr_limit[31:16];
               OFS_LIMIT_LO: r.read_data = tmr_limit[15:0];
               default:      r.read_data = '0;
            endcase
         end
         OP_WRITE: begin
            case (it.register_offset)
               OFS_MODE: begin
                  tmr_run    = wd[CTRL_RUN_BIT];
                  tmr_nmi_en = wd[CTRL_NMI_BIT];
                  tmr_irq_en = wd[CTRL_IRQ_BIT];
                  // load and copy both see the values from before the write
                  old_count = tmr_count;
                  old_stage = tmr_stage;
                  if (wd[CTRL_LOAD_BIT]) tmr_count = old_stage;
                  if (wd[CTRL_COPY_BIT]) tmr_stage = old_count;
                  if (wd[CTRL_ACK_BIT])  tmr_pending = 1'b0;
               end
               OFS_STAGE_HI: tmr_stage[31:16] = wd;
               OFS_STAGE_LO: tmr_stage[15:0]  = wd;
               OFS_LIMIT_HI: tmr_limit[31:16] = wd;
               OFS_LIMIT_LO: tmr_limit[15:0]  = wd;
               default: ;
            endcase
         end
         OP_TICK: begin
            if (tmr_run) begin
               prior     = tmr_count;
               later     = prior + it.tick_cycles;
               tmr_count = later;
               // window [prior, later], split in two when the counter wraps
               if (later < prior)
                  hit = (tmr_limit <= later) || (tmr_limit >= prior);
               else
                  hit = (tmr_limit >= prior) && (tmr_limit <= later);
               if (hit) tmr_pending = 1'b1;
            end
         end
         default: ;
      endcase
      r.pending     = tmr_pending;
      r.irq_request = tmr_pending & tmr_irq_en;
      r.nmi_request = tmr_pending & tmr_nmi_en;
      return r;
   endfunction

   function automatic logic [15:0] ctl_word(input logic run, input logic nmi, input logic irq,
                                            input logic load, input logic copy, input logic ack);
      logic [15:0] w;
      w = '0;
      w[CTRL_RUN_BIT]  = run;
      w[CTRL_NMI_BIT]  = nmi;
      w[CTRL_IRQ_BIT]  = irq;
      w[CTRL_LOAD_BIT] = load;
      w[CTRL_COPY_BIT] = copy;
      w[CTRL_ACK_BIT]  = ack;
      return w;
   endfunction

   task automatic push_item(input logic [1:0] op, input logic [4:0] ofs,
                            input logic [15:0] data, input logic [31:0] cycles);
      mit_item_type it;
      it.op              = op;
      it.register_offset = ofs;
      it.write_data      = data;
      it.tick_cycles     = cycles;
      queued_items.push_back(it);
   endtask

   // ---------------------------------------------------------------------
   // Request driver: changes on the falling edge, holds until transfer
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      mit_item_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && !req_took) begin
         // offer still pending, keep it stable
      end else if (queued_items.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
         nxt = queued_items.pop_front();
         req_bus.valid           <= 1'b1;
         req_bus.op              <= nxt.op;
         req_bus.register_offset <= nxt.register_offset;
         req_bus.write_data      <= nxt.write_data;
         req_bus.tick_cycles     <= nxt.tick_cycles;
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Response receiver: random stalls, a calm stretch, and one long
   // hold-off while the sender keeps offering so both stages fill up
   // ---------------------------------------------------------------------
   int  hold_left;
   logic hold_done;

   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (!hold_done && accepted_count >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (calm) begin
         rsp_bus.ready <= 1'b1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: sample both channels at the rising edge
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      mit_item_type   seen;
      mit_result_type want;
      if (reset) begin
         req_took = 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_rsp.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected response rd=%h p=%b irq=%b nmi=%b", $realtime,
                           rsp_bus.read_data, rsp_bus.pending, rsp_bus.irq_request,
                           rsp_bus.nmi_request);
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_bus.read_data !== want.read_data || rsp_bus.pending !== want.pending ||
                   rsp_bus.irq_request !== want.irq_request ||
                   rsp_bus.nmi_request !== want.nmi_request) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: exp rd=%h p=%b irq=%b nmi=%b got rd=%h p=%b irq=%b nmi=%b",
                              $realtime, want.read_data, want.pending, want.irq_request,
                              want.nmi_request, rsp_bus.read_data, rsp_bus.pending,
                              rsp_bus.irq_request, rsp_bus.nmi_request);
               end
            end
         end
         req_took = req_bus.valid && req_bus.ready;
         if (req_took) begin
            seen.op              = req_bus.op;
            seen.register_offset = req_bus.register_offset;
            seen.write_data      = req_bus.write_data;
            seen.tick_cycles     = req_bus.tick_cycles;
            awaited_rsp.push_back(advance_timer(seen));
            accepted_count++;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus, reset and end of test
   // ---------------------------------------------------------------------
   initial begin
      logic [31:0] lim;
      logic [31:0] start;
      logic [15:0] ctl;
      int pick;
      int run_len;

      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid           = 1'b0;
      req_bus.op              = OP_READ;
      req_bus.register_offset = '0;
      req_bus.write_data      = '0;
      req_bus.tick_cycles     = '0;
      rsp_bus.ready           = 1'b0;
      req_took       = 1'b0;
      accepted_count = 0;
      mismatch_count = 0;
      cycle_count    = 0;
      hold_left      = 0;
      hold_done      = 1'b0;
      tmr_count   = '0;
      tmr_stage   = '0;
      tmr_limit   = '0;
      tmr_run     = 1'b0;
      tmr_nmi_en  = 1'b0;
      tmr_irq_en  = 1'b0;
      tmr_pending = 1'b0;

      // Directed part
      push_item(OP_READ,  OFS_LENGTH,   16'h0000, 32'h0);
      push_item(OP_READ,  5'd0,         16'h0000, 32'h0);          // unmapped read
      push_item(OP_WRITE, OFS_LIMIT_HI, 16'h0000, 32'h0);
      push_item(OP_WRITE, OFS_LIMIT_LO, 16'h0010, 32'h0);
      push_item(OP_WRITE, OFS_STAGE_HI, 16'hffff, 32'h0);
      push_item(OP_WRITE, OFS_STAGE_LO, 16'hfff0, 32'h0);
      push_item(OP_READ,  OFS_STAGE_HI, 16'hffff, 32'hffffffff);
      push_item(OP_READ,  OFS_STAGE_LO, 16'h0000, 32'h0);
      push_item(OP_READ,  OFS_LIMIT_LO, 16'h0000, 32'h0);
      push_item(OP_TICK,  OFS_MODE,     16'h0000, 32'hffffffff);   // disabled: no change
      push_item(OP_WRITE, OFS_LENGTH,   16'h1234, 32'h0);          // read-only: ignored
      push_item(OP_WRITE, 5'd5,         16'hffff, 32'h0);          // unmapped: ignored
      push_item(OP_UNDEFINED, OFS_MODE, 16'hffff, 32'hffffffff);
      // enable with both requests, counter loaded just below the wrap
      push_item(OP_WRITE, OFS_MODE, ctl_word(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0), 32'h0);
      push_item(OP_TICK,  OFS_MODE, 16'h0000, 32'h0000_0020);      // wraps onto the limit
      push_item(OP_READ,  OFS_MODE, 16'h0000, 32'h0);
      // acknowledge, drop irq mode, copy counter to staging
      push_item(OP_WRITE, OFS_MODE, ctl_word(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1), 32'h0);
      push_item(OP_READ,  OFS_STAGE_LO, 16'h0000, 32'h0);
      push_item(OP_TICK,  OFS_MODE, 16'h0000, 32'h0);              // zero tick, count == limit
      push_item(OP_WRITE, OFS_STAGE_LO, 16'h0005, 32'h0);
      // load and copy in one write: a swap of counter and staging
      push_item(OP_WRITE, OFS_MODE, ctl_word(1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1), 32'h0);
      push_item(OP_READ,  OFS_STAGE_LO, 16'h0000, 32'h0);
      push_item(OP_TICK,  OFS_MODE, 16'h0000, 32'hffffffff);       // full-range tick
      push_item(OP_WRITE, OFS_MODE, 16'hffff, 32'h0);
      push_item(OP_READ,  5'd28, 16'h0000, 32'h0);                 // unmapped read

      // Random part: mostly armed runs toward a limit, the rest noise
      while (queued_items.size() < 25 + RANDOM_ITEMS) begin
         if ($urandom_range(99) < 70) begin
            if ($urandom_range(99) < 25) lim = $urandom_range(0, 300);  // likely wraps
            else lim = $urandom;
            start = lim - $urandom_range(0, 600);
            push_item(OP_WRITE, OFS_LIMIT_HI, lim[31:16], $urandom);
            push_item(OP_WRITE, OFS_LIMIT_LO, lim[15:0], $urandom);
            push_item(OP_WRITE, OFS_STAGE_HI, start[31:16], $urandom);
            push_item(OP_WRITE, OFS_STAGE_LO, start[15:0], $urandom);
            ctl = 16'($urandom_range(0, 65535));
            ctl[CTRL_RUN_BIT]  = 1'b1;
            ctl[CTRL_LOAD_BIT] = 1'b1;
            push_item(OP_WRITE, OFS_MODE, ctl, $urandom);
            run_len = $urandom_range(3, 10);
            repeat (run_len) begin
               pick = $urandom_range(99);
               if (pick < 65) begin
                  push_item(OP_TICK, 5'($urandom_range(0, 31)), 16'($urandom_range(0, 65535)),
                            $urandom_range(0, 250));
               end else if (pick < 85) begin
                  push_item(OP_READ, 5'($urandom_range(24, 31)), 16'($urandom_range(0, 65535)),
                            32'h0);
               end else begin
                  // acknowledge, keep running, fresh request modes
                  ctl = 16'($urandom_range(0, 65535));
                  ctl[CTRL_RUN_BIT]  = 1'b1;
                  ctl[CTRL_LOAD_BIT] = 1'b0;
                  ctl[CTRL_ACK_BIT]  = 1'b1;
                  push_item(OP_WRITE, OFS_MODE, ctl, 32'h0);
               end
            end
         end else begin
            pick = $urandom_range(99);
            if (pick < 20) lim = $urandom;
            else if (pick < 50) lim = $urandom_range(0, 65535);
            else lim = $urandom_range(0, 255);
            push_item((pick % 20 == 0) ? OP_UNDEFINED : 2'($urandom_range(0, 2)),
                      5'($urandom_range(0, 31)), 16'($urandom_range(0, 65535)), lim);
         end
      end
      total_items = queued_items.size();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (accepted_count < total_items) @(posedge clock);
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && awaited_rsp.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
